[rtl/rgbcsn_pkg.sv]
// Shared widths, register codes, reset values and divider step functions for the normalizer.
package rgbcsn_pkg;

	localparam int RAW_W   = 16;
	localparam int CFG_W   = 16;
	localparam int OUT_W   = 8;
	localparam int IDX_W   = 3;
	localparam int RATIO_W = 24;
	localparam int PROD_W  = 34;
	localparam int SUM_W   = 26;
	localparam int DIFF_W  = 27;
	localparam int BPROD_W = 44;
	localparam int BNUM_W  = 45;
	localparam int X_W     = 32;
	localparam int V_W     = 30;
	localparam int ON_W    = 38;

	localparam int RDIV_PER = 2;
	localparam int RDIV_ST  = RATIO_W / RDIV_PER;
	localparam int ODIV_PER = 2;
	localparam int ODIV_ST  = OUT_W / ODIV_PER;

	localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
	// Reciprocal of three for a 32-bit dividend, used with a shift of 33.
	localparam logic [X_W-1:0]     RECIP3    = 32'hAAAA_AAAB;
	localparam int                 RECIP_SH  = 33;
	localparam int                 Q_SHIFT   = 12;

	localparam logic [CFG_W-1:0] RST_GAIN_RED   = 16'd16384;
	localparam logic [CFG_W-1:0] RST_GAIN_GREEN = 16'd18842;
	localparam logic [CFG_W-1:0] RST_GAIN_BLUE  = 16'd20480;
	localparam logic [CFG_W-1:0] RST_BOOST      = 16'd7373;
	localparam logic [CFG_W-1:0] RST_GREY_THR   = 16'd1311;

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_RED   = 3'd0,
		REG_GAIN_GREEN = 3'd1,
		REG_GAIN_BLUE  = 3'd2,
		REG_BOOST      = 3'd3,
		REG_GREY_THR   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [PROD_W-1:0]  rem;
		logic [RATIO_W-1:0] quo;
	} rdiv_t;

	typedef struct packed {
		logic [ON_W-1:0]  rem;
		logic [OUT_W-1:0] quo;
	} odiv_t;

	typedef struct packed {
		logic             blk;
		logic [RAW_W-1:0] clear;
		logic [2:0]       sat;
		rdiv_t [2:0]      ch;
	} rstage_t;

	typedef struct packed {
		logic             nb;
		logic [V_W-1:0]   d;
		odiv_t [2:0]      ch;
	} ostage_t;

	function automatic rdiv_t rdiv_step(rdiv_t cur, logic [RAW_W-1:0] d, int top);
		rdiv_t r;
		int    b;
		r = cur;
		for (int j = 0; j < RDIV_PER; j++) begin
			b = top - j;
			if ((r.rem >> b) >= PROD_W'(d)) begin
				r.rem = r.rem - (PROD_W'(d) << b);
				r.quo = r.quo | (RATIO_W'(1) << b);
			end
		end
		return r;
	endfunction

	function automatic odiv_t odiv_step(odiv_t cur, logic [V_W-1:0] d, int top);
		odiv_t r;
		int    b;
		r = cur;
		for (int j = 0; j < ODIV_PER; j++) begin
			b = top - j;
			if ((r.rem >> b) >= ON_W'(d)) begin
				r.rem = r.rem - (ON_W'(d) << b);
				r.quo = r.quo | (OUT_W'(1) << b);
			end
		end
		return r;
	endfunction

endpackage

[rtl/rgbc_color_saturation_normalizer_top.sv]
// Top level of the RGBC color saturation normalizer: a fully pipelined datapath.
//
//   Channel  Direction  Handshake            Beat contents
//   input    in         start / busy         raw_red, raw_green, raw_blue, raw_clear
//   result   out        done (strobe)        out_red, out_green, out_blue
//   config   in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample is accepted every clock cycle; busy never rises since no stage can stall.
// Each sample passes through the two restoring dividers (twelve stages for the ratio,
// four for the output scale), two bits per stage, plus the multiply, boost and max stages
// around them before it appears on the result ports.
// Reset clears the valid bits and loads the registers with their documented defaults.
// The receiver cannot hold results off, so each result beat is shown for one cycle only.
module rgbc_color_saturation_normalizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rgbcsn_pkg::RAW_W-1:0]  raw_red,
	input  logic [rgbcsn_pkg::RAW_W-1:0]  raw_green,
	input  logic [rgbcsn_pkg::RAW_W-1:0]  raw_blue,
	input  logic [rgbcsn_pkg::RAW_W-1:0]  raw_clear,
	output logic                          done,
	output logic [rgbcsn_pkg::OUT_W-1:0]  out_red,
	output logic [rgbcsn_pkg::OUT_W-1:0]  out_green,
	output logic [rgbcsn_pkg::OUT_W-1:0]  out_blue,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rgbcsn_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rgbcsn_pkg::CFG_W-1:0]  cfg_data
);
	import rgbcsn_pkg::*;

	// Configuration registers. The user must send writes only while the pipeline is empty;
	// the block does not enforce this, and the later stages read the registers directly.
	logic [CFG_W-1:0] gain_red_q, gain_green_q, gain_blue_q, boost_q, grey_thr_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_red_q   <= RST_GAIN_RED;
			gain_green_q <= RST_GAIN_GREEN;
			gain_blue_q  <= RST_GAIN_BLUE;
			boost_q      <= RST_BOOST;
			grey_thr_q   <= RST_GREY_THR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_GAIN_RED:   gain_red_q   <= cfg_data;
				REG_GAIN_GREEN: gain_green_q <= cfg_data;
				REG_GAIN_BLUE:  gain_blue_q  <= cfg_data;
				REG_BOOST:      boost_q      <= cfg_data;
				REG_GREY_THR:   grey_thr_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: white-balance products.
	logic                      vld_s1;
	logic [2*RAW_W-1:0]        prod_s1 [3];
	logic [RAW_W-1:0]          clear_s1;

	always_ff @(posedge clk) begin
		prod_s1[0] <= raw_red   * gain_red_q;
		prod_s1[1] <= raw_green * gain_green_q;
		prod_s1[2] <= raw_blue  * gain_blue_q;
		clear_s1   <= raw_clear;
	end

	// Ratio divider: numerator is the product times four. When the top bits already
	// reach the divisor the quotient would not fit in Q8.16, so it saturates.
	rstage_t rd_in [RDIV_ST];
	rstage_t rd_nx_c [RDIV_ST];
	rstage_t rd_s2 [RDIV_ST];
	logic    rd_vld_s2 [RDIV_ST];

	always_comb begin
		rd_in[0].blk   = (clear_s1 == '0);
		rd_in[0].clear = clear_s1;
		for (int c = 0; c < 3; c++) begin
			rd_in[0].ch[c].rem = {prod_s1[c], 2'b00};
			rd_in[0].ch[c].quo = '0;
			rd_in[0].sat[c]    = (PROD_W'({prod_s1[c], 2'b00}) >> RATIO_W) >= PROD_W'(clear_s1);
		end
		for (int k = 1; k < RDIV_ST; k++) begin
			rd_in[k] = rd_s2[k-1];
		end
	end

	always_comb begin
		for (int k = 0; k < RDIV_ST; k++) begin
			rd_nx_c[k] = rd_in[k];
			for (int c = 0; c < 3; c++) begin
				rd_nx_c[k].ch[c] = rdiv_step(rd_in[k].ch[c], rd_in[k].clear,
					RATIO_W - 1 - k * RDIV_PER);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < RDIV_ST; k++) begin
			rd_s2[k] <= rd_nx_c[k];
		end
	end

	// Stage 3: saturated ratios.
	logic               vld_s3, blk_s3;
	logic [RATIO_W-1:0] ratio_s3 [3];

	always_ff @(posedge clk) begin
		blk_s3 <= rd_s2[RDIV_ST-1].blk;
		for (int c = 0; c < 3; c++) begin
			ratio_s3[c] <= rd_s2[RDIV_ST-1].sat[c] ? RATIO_MAX : rd_s2[RDIV_ST-1].ch[c].quo;
		end
	end

	// Stage 4: spread test against the grey threshold, and the channel sum.
	logic               vld_s4, blk_s4, boost_s4;
	logic [RATIO_W-1:0] ratio_s4 [3];
	logic [SUM_W-1:0]   sum_s4;
	logic [RATIO_W-1:0] hi_c, lo_c;

	always_comb begin
		hi_c = ratio_s3[0];
		lo_c = ratio_s3[0];
		for (int c = 1; c < 3; c++) begin
			if (ratio_s3[c] > hi_c) hi_c = ratio_s3[c];
			if (ratio_s3[c] < lo_c) lo_c = ratio_s3[c];
		end
	end

	always_ff @(posedge clk) begin
		blk_s4   <= blk_s3;
		boost_s4 <= (hi_c - lo_c) > RATIO_W'(grey_thr_q);
		sum_s4   <= SUM_W'(ratio_s3[0]) + SUM_W'(ratio_s3[1]) + SUM_W'(ratio_s3[2]);
		ratio_s4 <= ratio_s3;
	end

	// Stage 5: distance from the mean (as 3r - S) times the boost factor.
	logic                      vld_s5, blk_s5, boost_s5;
	logic [RATIO_W-1:0]        ratio_s5 [3];
	logic [SUM_W-1:0]          sum_s5;
	logic signed [BPROD_W-1:0] bprod_s5 [3];
	logic signed [DIFF_W-1:0]  diff_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			diff_c[c] = $signed({1'b0, SUM_W'(ratio_s4[c]) + SUM_W'({ratio_s4[c], 1'b0})})
				- $signed({1'b0, sum_s4});
		end
	end

	always_ff @(posedge clk) begin
		blk_s5   <= blk_s4;
		boost_s5 <= boost_s4;
		sum_s5   <= sum_s4;
		ratio_s5 <= ratio_s4;
		for (int c = 0; c < 3; c++) begin
			bprod_s5[c] <= BPROD_W'(diff_c[c] * $signed({1'b0, boost_q}));
		end
	end

	// Stage 6: numerator over 4096, negative or zero numerators give zero.
	logic               vld_s6, blk_s6, boost_s6;
	logic [RATIO_W-1:0] ratio_s6 [3];
	logic [X_W-1:0]     x_s6 [3];
	logic signed [BNUM_W-1:0] num_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num_c[c] = $signed({{(BNUM_W-SUM_W-Q_SHIFT){1'b0}}, sum_s5, {Q_SHIFT{1'b0}}})
				+ $signed({bprod_s5[c][BPROD_W-1], bprod_s5[c]});
		end
	end

	always_ff @(posedge clk) begin
		blk_s6   <= blk_s5;
		boost_s6 <= boost_s5;
		ratio_s6 <= ratio_s5;
		for (int c = 0; c < 3; c++) begin
			x_s6[c] <= (num_c[c] > 0) ? num_c[c][Q_SHIFT+X_W-1:Q_SHIFT] : '0;
		end
	end

	// Stage 7: divide by three through the reciprocal; pick boosted or plain value.
	logic             vld_s7, blk_s7;
	logic [V_W-1:0]   v_s7 [3];
	logic [2*X_W-1:0] rmul_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rmul_c[c] = x_s6[c] * RECIP3;
		end
	end

	always_ff @(posedge clk) begin
		blk_s7 <= blk_s6;
		for (int c = 0; c < 3; c++) begin
			v_s7[c] <= boost_s6 ? rmul_c[c][RECIP_SH+V_W-1:RECIP_SH] : V_W'(ratio_s6[c]);
		end
	end

	// Stage 8: largest value and the scaled numerators v*255.
	logic           vld_s8;
	ostage_t        od_s8;
	logic [V_W-1:0] top_c;

	always_comb begin
		top_c = v_s7[0];
		for (int c = 1; c < 3; c++) begin
			if (v_s7[c] > top_c) top_c = v_s7[c];
		end
	end

	always_ff @(posedge clk) begin
		od_s8.nb <= !blk_s7 && (top_c != '0);
		od_s8.d  <= top_c;
		for (int c = 0; c < 3; c++) begin
			od_s8.ch[c].rem <= {v_s7[c], 8'b0} - ON_W'(v_s7[c]);
			od_s8.ch[c].quo <= '0;
		end
	end

	// Output divider: eight quotient bits, since no value exceeds the largest.
	ostage_t od_in [ODIV_ST];
	ostage_t od_nx_c [ODIV_ST];
	ostage_t od_s9 [ODIV_ST];
	logic    od_vld_s9 [ODIV_ST];

	always_comb begin
		od_in[0] = od_s8;
		for (int k = 1; k < ODIV_ST; k++) begin
			od_in[k] = od_s9[k-1];
		end
	end

	always_comb begin
		for (int k = 0; k < ODIV_ST; k++) begin
			od_nx_c[k] = od_in[k];
			for (int c = 0; c < 3; c++) begin
				od_nx_c[k].ch[c] = odiv_step(od_in[k].ch[c], od_in[k].d,
					OUT_W - 1 - k * ODIV_PER);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ODIV_ST; k++) begin
			od_s9[k] <= od_nx_c[k];
		end
	end

	// Output register: black for a zero clear or when all three channel values are zero.
	logic             done_q, nb_q;
	logic [OUT_W-1:0] out_q [3];

	always_ff @(posedge clk) begin
		nb_q <= od_s9[ODIV_ST-1].nb;
		for (int c = 0; c < 3; c++) begin
			out_q[c] <= od_s9[ODIV_ST-1].nb ? od_s9[ODIV_ST-1].ch[c].quo : '0;
		end
	end

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k < RDIV_ST; k++) rd_vld_s2[k] <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			for (int k = 0; k < ODIV_ST; k++) od_vld_s9[k] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1       <= start && !busy;
			rd_vld_s2[0] <= vld_s1;
			for (int k = 1; k < RDIV_ST; k++) rd_vld_s2[k] <= rd_vld_s2[k-1];
			vld_s3 <= rd_vld_s2[RDIV_ST-1];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			od_vld_s9[0] <= vld_s8;
			for (int k = 1; k < ODIV_ST; k++) od_vld_s9[k] <= od_vld_s9[k-1];
			done_q <= od_vld_s9[ODIV_ST-1];
		end
	end

	assign done      = done_q;
	assign out_red   = out_q[0];
	assign out_green = out_q[1];
	assign out_blue  = out_q[2];

	// A result that is not black always has its strongest channel stretched to full scale.
	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		done && nb_q |-> (out_red == 8'hFF || out_green == 8'hFF || out_blue == 8'hFF))
		else $error("non-black result without a full-scale channel");

	// A result strobe comes only from an item that left the max stage earlier.
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s8, ODIV_ST + 1))
		else $error("result strobe without a matching item in the pipeline");

	// A black result carries all-zero drive levels.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		done && !nb_q |-> (out_red == '0 && out_green == '0 && out_blue == '0))
		else $error("black result with nonzero drive level");

endmodule
